// ===== rtl/core/thbs_pkg.sv =====
// Shared types and constants for the tiled heightmap bilinear sampler.
package thbs_pkg;

	localparam int HEIGHT_DEPTH = 65536;
	localparam int HADDR_W      = $clog2(HEIGHT_DEPTH);
	localparam int MAX_TILES    = 256;
	localparam int TILE_W       = $clog2(MAX_TILES);
	localparam int MAX_SAMPLES  = 16;
	localparam int HEIGHT_W     = 24;
	localparam int WGT_W        = 17;
	localparam logic [WGT_W-1:0] WGT_ONE = 17'd65536;
	localparam int AX_LAT       = 30;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		OP_WR_HEIGHT  = 2'd0,
		OP_WR_PRESENT = 2'd1,
		OP_QUERY      = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_TILE_SIZE = 3'd2,
		REG_TILES_X   = 3'd3,
		REG_TILES_Y   = 3'd4,
		REG_SAMPLES   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		op_t                        op;
		logic [15:0]                addr;
		logic signed [HEIGHT_W-1:0] value;
		logic                       present;
	} item_t;

	typedef struct packed {
		item_t              it;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
	} qent_t;

	// Clamped geometry plus the products that the pipeline compares against.
	typedef struct packed {
		logic [30:0] ts;
		logic [4:0]  ntx;
		logic [4:0]  nty;
		logic [4:0]  n;
		logic [3:0]  nm1;
		logic [8:0]  nn;
		logic [35:0] limx;
		logic [35:0] limy;
		logic [34:0] limmx;
		logic [34:0] limmy;
		logic [34:0] pts;
	} geom_t;

	typedef struct packed {
		logic [3:0]       idx;
		logic             inr;
		logic [3:0]       p;
		logic [WGT_W-1:0] w;
	} axres_t;

endpackage

// ===== rtl/core/thbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module thbs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/thbs_front.sv =====
// Front end: accepts input transactions, decodes the kind and forms queue entries.
module thbs_front
	import thbs_pkg::*;
(
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [111:0]       s_axis_tdata,
	input  logic [1:0]         s_axis_tuser,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic               q_full,
	output logic               q_push,
	output qent_t              q_ent
);

	logic signed [31:0] qx, qy;
	logic               known;

	assign s_axis_tready = !q_full;
	assign qx = $signed(s_axis_tdata[72:41]);
	assign qy = $signed(s_axis_tdata[104:73]);

	always_comb begin
		unique case (s_axis_tuser)
			OP_WR_HEIGHT, OP_WR_PRESENT, OP_QUERY: known = 1'b1;
			default:                               known = 1'b0;
		endcase
	end

	// unknown kinds are taken and dropped
	assign q_push = s_axis_tvalid && !q_full && known;

	always_comb begin
		q_ent.it.op      = op_t'(s_axis_tuser);
		q_ent.it.addr    = s_axis_tdata[15:0];
		q_ent.it.value   = $signed(s_axis_tdata[39:16]);
		q_ent.it.present = s_axis_tdata[40];
		q_ent.dx         = 33'(qx) - 33'(origin_x);
		q_ent.dy         = 33'(qy) - 33'(origin_y);
	end

endmodule

// ===== rtl/core/thbs_queue.sv =====
// Short FIFO between front end and back end.
module thbs_queue
	import thbs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t ent_in,
	input  logic  pop,
	output logic  full,
	output logic  valid,
	output qent_t head
);

	qent_t             ent_q [0:QDEPTH-1];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign valid   = (cnt_q != '0);
	assign head    = ent_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop) rptr_q <= rptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wptr_q] <= ent_in;
		end
	end

endmodule

// ===== rtl/core/thbs_axis.sv =====
// One coordinate axis: tile index, sample cell and weight by restoring steps.
module thbs_axis
	import thbs_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic signed [32:0] d,
	input  logic [30:0]        ts,
	input  logic [4:0]         nt,
	input  logic [3:0]         nm1,
	input  logic [35:0]        lim,
	input  logic [34:0]        limm,
	input  logic [34:0]        pts,
	output axres_t             res
);

	typedef struct packed {
		logic signed [41:0] v;
		logic signed [41:0] alt;
		logic               neg;
		logic               over;
		logic [35:0]        r;
		logic [15:0]        q;
		logic [3:0]         idx;
		logic               inr;
		logic [3:0]         p;
	} ax_t;

	ax_t st_s [1:AX_LAT];
	ax_t nxt  [1:AX_LAT];

	// stage 1: classify against the grid; 2-5: tile quotient; 6: tile residual
	// 7: scale by n-1; 8: classify; 9-12: cell quotient; 13: cell residual
	// 14: weight classify; 15-30: sixteen fraction bits of residual / ts
	always_comb begin
		logic [35:0] sh;
		logic [35:0] r2;
		sh = '0;
		r2 = '0;
		nxt[1].v    = 42'(d);
		nxt[1].alt  = 42'(d) - 42'(limm);
		nxt[1].neg  = d[32];
		nxt[1].over = !d[32] && (36'(d[31:0]) >= lim);
		nxt[1].r    = 36'(d[31:0]);
		nxt[1].q    = '0;
		nxt[1].idx  = '0;
		nxt[1].inr  = 1'b0;
		nxt[1].p    = '0;
		for (int k = 2; k <= AX_LAT; k++) begin
			sh = '0;
			r2 = '0;
			nxt[k] = st_s[k-1];
			if (k <= 5) begin
				sh = 36'(ts) << (5 - k);
				if (st_s[k-1].r >= sh) begin
					nxt[k].r        = st_s[k-1].r - sh;
					nxt[k].q[5 - k] = 1'b1;
				end
			end else if (k == 6) begin
				nxt[k].inr = !st_s[k-1].neg && !st_s[k-1].over;
				if (st_s[k-1].neg) begin
					nxt[k].idx = '0;
				end else if (st_s[k-1].over) begin
					nxt[k].idx = 4'(nt - 5'd1);
					nxt[k].v   = st_s[k-1].alt;
				end else begin
					nxt[k].idx = st_s[k-1].q[3:0];
					nxt[k].v   = 42'(st_s[k-1].r);
				end
			end else if (k == 7) begin
				nxt[k].v = 42'($signed(st_s[k-1].v) * $signed({1'b0, nm1}));
			end else if (k == 8) begin
				nxt[k].neg  = st_s[k-1].v[41];
				nxt[k].over = !st_s[k-1].v[41] && (st_s[k-1].v[40:0] >= 41'(pts));
				nxt[k].alt  = st_s[k-1].v - 42'(pts);
				nxt[k].r    = st_s[k-1].v[35:0];
				nxt[k].q    = '0;
			end else if (k <= 12) begin
				sh = 36'(ts) << (12 - k);
				if (st_s[k-1].r >= sh) begin
					nxt[k].r         = st_s[k-1].r - sh;
					nxt[k].q[12 - k] = 1'b1;
				end
			end else if (k == 13) begin
				if (st_s[k-1].neg) begin
					nxt[k].p = '0;
				end else if (st_s[k-1].over) begin
					nxt[k].p = nm1;
					nxt[k].v = st_s[k-1].alt;
				end else begin
					nxt[k].p = st_s[k-1].q[3:0];
					nxt[k].v = 42'(st_s[k-1].r);
				end
			end else if (k == 14) begin
				nxt[k].neg  = st_s[k-1].v[41] || (st_s[k-1].v == '0);
				nxt[k].over = !st_s[k-1].v[41] && (st_s[k-1].v[40:0] >= 41'(ts));
				nxt[k].r    = 36'(st_s[k-1].v[30:0]);
				nxt[k].q    = '0;
			end else begin
				r2 = {st_s[k-1].r[34:0], 1'b0};
				if (r2 >= 36'(ts)) begin
					r2               = r2 - 36'(ts);
					nxt[k].q[30 - k] = 1'b1;
				end
				nxt[k].r = r2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= AX_LAT; k++) begin
				st_s[k] <= nxt[k];
			end
		end
	end

	always_comb begin
		res.idx = st_s[AX_LAT].idx;
		res.inr = st_s[AX_LAT].inr;
		res.p   = st_s[AX_LAT].p;
		if (st_s[AX_LAT].neg) res.w = '0;
		else if (st_s[AX_LAT].over) res.w = WGT_ONE;
		else res.w = {1'b0, st_s[AX_LAT].q};
	end

endmodule

// ===== rtl/core/thbs_back.sv =====
// Back end: coordinate pipeline, height and present stores, bilinear blend.
module thbs_back
	import thbs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  geom_t               geom,
	input  logic                q_valid,
	input  qent_t               q_head,
	output logic                q_pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [HEIGHT_W-1:0] m_axis_tdata,
	output logic                m_axis_tuser
);

	logic              en;
	logic [1:AX_LAT]   vld_s;
	item_t             it_s [1:AX_LAT];
	axres_t            rx, ry;

	// stage 31: tile index and row offsets
	logic              v_s31, cov_s31;
	item_t             it_s31;
	logic [TILE_W-1:0] tile_s31;
	logic [3:0]        px_s31, px1_s31;
	logic [7:0]        ro0_s31, ro1_s31;
	logic [WGT_W-1:0]  wx_s31, wy_s31;
	logic [3:0]        py1;
	// stage 32: tile base, store access
	logic              v_s32, cov_s32;
	item_t             it_s32;
	logic [TILE_W-1:0] tile_s32;
	logic [HADDR_W-1:0] base_s32;
	logic [3:0]        px_s32, px1_s32;
	logic [7:0]        ro0_s32, ro1_s32;
	logic [WGT_W-1:0]  wx_s32, wy_s32;
	logic [HADDR_W-1:0] a00, a01, a10, a11;
	logic              h_we;
	// stage 33: heights from the store
	logic              v_s33, cov_s33;
	logic [WGT_W-1:0]  wx_s33, wy_s33;
	logic [HEIGHT_W-1:0] h00, h01, h10, h11;
	// stage 34: x products
	logic              v_s34, cov_s34;
	logic [WGT_W-1:0]  wy_s34;
	logic signed [41:0] p00_s34, p01_s34, p10_s34, p11_s34;
	// stage 35: row blends
	logic              v_s35, cov_s35;
	logic [WGT_W-1:0]  wy_s35;
	logic signed [HEIGHT_W-1:0] a_s35, b_s35;
	logic signed [41:0] sa, sb, sr;
	// stage 36: y products
	logic              v_s36, cov_s36;
	logic signed [41:0] pa_s36, pb_s36;
	// stage 37: result register
	logic              v_s37, cov_s37;
	logic [HEIGHT_W-1:0] height_s37;

	logic [MAX_TILES-1:0] pres_q;

	assign en    = !v_s37 || m_axis_tready;
	assign q_pop = en && q_valid;

	thbs_axis u_axis_x (
		.clk  (clk),
		.en   (en),
		.d    (q_head.dx),
		.ts   (geom.ts),
		.nt   (geom.ntx),
		.nm1  (geom.nm1),
		.lim  (geom.limx),
		.limm (geom.limmx),
		.pts  (geom.pts),
		.res  (rx)
	);

	thbs_axis u_axis_y (
		.clk  (clk),
		.en   (en),
		.d    (q_head.dy),
		.ts   (geom.ts),
		.nt   (geom.nty),
		.nm1  (geom.nm1),
		.lim  (geom.limy),
		.limm (geom.limmy),
		.pts  (geom.pts),
		.res  (ry)
	);

	assign py1 = (ry.p == geom.nm1) ? ry.p : ry.p + 4'd1;

	assign a00 = base_s32 + HADDR_W'(ro0_s32) + HADDR_W'(px_s32);
	assign a01 = base_s32 + HADDR_W'(ro0_s32) + HADDR_W'(px1_s32);
	assign a10 = base_s32 + HADDR_W'(ro1_s32) + HADDR_W'(px_s32);
	assign a11 = base_s32 + HADDR_W'(ro1_s32) + HADDR_W'(px1_s32);
	// writes land in the same stage as query reads, so program order holds
	assign h_we = en && v_s32 && (it_s32.op == OP_WR_HEIGHT);

	thbs_ram #(.WIDTH(HEIGHT_W), .DEPTH(HEIGHT_DEPTH)) u_ram00 (
		.clk(clk), .we(h_we), .waddr(it_s32.addr), .wdata(it_s32.value),
		.re(en), .raddr(a00), .rdata(h00)
	);
	thbs_ram #(.WIDTH(HEIGHT_W), .DEPTH(HEIGHT_DEPTH)) u_ram01 (
		.clk(clk), .we(h_we), .waddr(it_s32.addr), .wdata(it_s32.value),
		.re(en), .raddr(a01), .rdata(h01)
	);
	thbs_ram #(.WIDTH(HEIGHT_W), .DEPTH(HEIGHT_DEPTH)) u_ram10 (
		.clk(clk), .we(h_we), .waddr(it_s32.addr), .wdata(it_s32.value),
		.re(en), .raddr(a10), .rdata(h10)
	);
	thbs_ram #(.WIDTH(HEIGHT_W), .DEPTH(HEIGHT_DEPTH)) u_ram11 (
		.clk(clk), .we(h_we), .waddr(it_s32.addr), .wdata(it_s32.value),
		.re(en), .raddr(a11), .rdata(h11)
	);

	assign sa = p00_s34 + p01_s34 + 42'sd32768;
	assign sb = p10_s34 + p11_s34 + 42'sd32768;
	assign sr = pa_s36 + pb_s36 + 42'sd32768;

	// control: valid bits and present flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			v_s31  <= 1'b0;
			v_s32  <= 1'b0;
			v_s33  <= 1'b0;
			v_s34  <= 1'b0;
			v_s35  <= 1'b0;
			v_s36  <= 1'b0;
			v_s37  <= 1'b0;
			pres_q <= '0;
		end else if (en) begin
			vld_s[1] <= q_valid;
			for (int k = 2; k <= AX_LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			v_s31 <= vld_s[AX_LAT];
			v_s32 <= v_s31;
			v_s33 <= v_s32 && (it_s32.op == OP_QUERY);
			v_s34 <= v_s33;
			v_s35 <= v_s34;
			v_s36 <= v_s35;
			v_s37 <= v_s36;
			if (v_s32 && (it_s32.op == OP_WR_PRESENT)) begin
				pres_q[it_s32.addr[TILE_W-1:0]] <= it_s32.present;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			it_s[1] <= q_head.it;
			for (int k = 2; k <= AX_LAT; k++) begin
				it_s[k] <= it_s[k-1];
			end

			it_s31   <= it_s[AX_LAT];
			tile_s31 <= TILE_W'(ry.idx * geom.ntx + rx.idx);
			cov_s31  <= rx.inr && ry.inr;
			px_s31   <= rx.p;
			px1_s31  <= (rx.p == geom.nm1) ? rx.p : rx.p + 4'd1;
			ro0_s31  <= 8'(ry.p * geom.n);
			ro1_s31  <= 8'(py1 * geom.n);
			wx_s31   <= rx.w;
			wy_s31   <= ry.w;

			it_s32   <= it_s31;
			tile_s32 <= tile_s31;
			base_s32 <= HADDR_W'(17'(tile_s31) * 17'(geom.nn));
			cov_s32  <= cov_s31;
			px_s32   <= px_s31;
			px1_s32  <= px1_s31;
			ro0_s32  <= ro0_s31;
			ro1_s32  <= ro1_s31;
			wx_s32   <= wx_s31;
			wy_s32   <= wy_s31;

			cov_s33 <= cov_s32 && pres_q[tile_s32];
			wx_s33  <= wx_s32;
			wy_s33  <= wy_s32;

			cov_s34 <= cov_s33;
			wy_s34  <= wy_s33;
			p00_s34 <= 42'($signed(h00) * $signed({1'b0, WGT_ONE - wx_s33}));
			p01_s34 <= 42'($signed(h01) * $signed({1'b0, wx_s33}));
			p10_s34 <= 42'($signed(h10) * $signed({1'b0, WGT_ONE - wx_s33}));
			p11_s34 <= 42'($signed(h11) * $signed({1'b0, wx_s33}));

			cov_s35 <= cov_s34;
			wy_s35  <= wy_s34;
			a_s35   <= sa[39:16];
			b_s35   <= sb[39:16];

			cov_s36 <= cov_s35;
			pa_s36  <= 42'(a_s35 * $signed({1'b0, WGT_ONE - wy_s35}));
			pb_s36  <= 42'(b_s35 * $signed({1'b0, wy_s35}));

			cov_s37    <= cov_s36;
			height_s37 <= sr[39:16];
		end
	end

	assign m_axis_tvalid = v_s37;
	assign m_axis_tdata  = height_s37;
	assign m_axis_tuser  = cov_s37;

endmodule

// ===== rtl/core/tiled_heightmap_bilinear_sampler.sv =====
// Top level of the tiled heightmap bilinear sampler.
//
// Usage:
//  - s_axis carries write and query transactions; tuser holds the kind
//    (height write, present-bit write, query). Unknown kinds are taken and
//    dropped. Only queries produce an m_axis transaction.
//  - Heights are written into a 64K-entry store, present bits into a
//    256-entry flag table; both take effect in input order relative to
//    queries.
//  - Throughput: one transaction per cycle, sustained, in either direction,
//    while m_axis_tready stays high. Most of a query's pipeline is the
//    per-axis restoring-division section (tile index, sample cell, 16-fraction-bit
//    weight), followed by address generation, the four-ported height read
//    (four store copies) and the two-level blend.
//  - A 4-entry queue sits between the input decoder and the pipeline, so
//    input keeps being accepted while a result waits; when m_axis_tready is
//    low the pipeline holds and the queue fills, then s_axis_tready drops.
//  - Reset clears config to its defaults, the present bits and all valids.
//    Heights are undefined until written. Make config writes only while idle (not enforced).
module tiled_heightmap_bilinear_sampler
	import thbs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// address[15:0], height_value[39:16], present_bit[40], query_x[72:41],
	// query_y[104:73], zero pad[111:105]
	input  logic [111:0] s_axis_tdata,
	// kind[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// height[23:0]
	output logic [23:0]  m_axis_tdata,
	// covered[0]
	output logic         m_axis_tuser
);

	logic signed [31:0] origin_x_q, origin_y_q;
	logic [30:0]        tile_size_q;
	logic [4:0]         tiles_x_q, tiles_y_q, samples_q;
	geom_t              geom_q;

	logic [30:0] ts_c;
	logic [4:0]  ntx_c, nty_c, n_c;

	logic  q_full, q_push, q_valid, q_pop;
	qent_t q_ent, q_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			tile_size_q <= 31'd39136;
			tiles_x_q   <= 5'd1;
			tiles_y_q   <= 5'd1;
			samples_q   <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X:  origin_x_q  <= $signed(cfg_data);
				REG_ORIGIN_Y:  origin_y_q  <= $signed(cfg_data);
				REG_TILE_SIZE: tile_size_q <= cfg_data[30:0];
				REG_TILES_X:   tiles_x_q   <= cfg_data[4:0];
				REG_TILES_Y:   tiles_y_q   <= cfg_data[4:0];
				REG_SAMPLES:   samples_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// saturate out-of-range geometry
	always_comb begin
		ts_c  = (tile_size_q == '0) ? 31'd1 : tile_size_q;
		ntx_c = (tiles_x_q == '0) ? 5'd1 : ((tiles_x_q > 5'd16) ? 5'd16 : tiles_x_q);
		nty_c = (tiles_y_q == '0) ? 5'd1 : ((tiles_y_q > 5'd16) ? 5'd16 : tiles_y_q);
		n_c   = (samples_q < 5'd2) ? 5'd2 :
			((samples_q > 5'(MAX_SAMPLES)) ? 5'(MAX_SAMPLES) : samples_q);
	end

	// derived geometry, refreshed every cycle from the config registers
	always_ff @(posedge clk) begin
		geom_q.ts    <= ts_c;
		geom_q.ntx   <= ntx_c;
		geom_q.nty   <= nty_c;
		geom_q.n     <= n_c;
		geom_q.nm1   <= 4'(n_c - 5'd1);
		geom_q.nn    <= 9'(n_c * n_c);
		geom_q.limx  <= 36'(ntx_c) * 36'(ts_c);
		geom_q.limy  <= 36'(nty_c) * 36'(ts_c);
		geom_q.limmx <= 35'(ntx_c - 5'd1) * 35'(ts_c);
		geom_q.limmy <= 35'(nty_c - 5'd1) * 35'(ts_c);
		geom_q.pts   <= 35'(n_c - 5'd1) * 35'(ts_c);
	end

	thbs_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.origin_x      (origin_x_q),
		.origin_y      (origin_y_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_ent         (q_ent)
	);

	thbs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.ent_in (q_ent),
		.pop    (q_pop),
		.full   (q_full),
		.valid  (q_valid),
		.head   (q_head)
	);

	thbs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.geom          (geom_q),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== tb/tiled_heightmap_bilinear_sampler_test.sv =====
// Testbench for the tiled heightmap bilinear sampler: random writes and queries checked against a predictor.
`timescale 1ns / 1ps

module tiled_heightmap_bilinear_sampler_test;
	import thbs_pkg::*;

	// One input transaction as the sender sees it.
	typedef struct {
		op_t         kind;
		logic [15:0] addr;
		logic [23:0] value;
		logic        present;
		int          qx;
		int          qy;
	} txn_t;

	// One expected output transaction.
	typedef struct {
		logic [23:0] height;
		logic        covered;
	} sample_t;

	// Corner addresses and weights for one query point.
	typedef struct packed {
		logic [3:0][15:0] adr;
		longint           wx;
		longint           wy;
		bit               covered;
	} cell_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [23:0]  m_axis_tdata;
	logic         m_axis_tuser;

	tiled_heightmap_bilinear_sampler DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Configuration mirror; only changes while the block is idle.
	int          org_x = 0;
	int          org_y = 0;
	logic [30:0] tile_len = 31'd39136;
	logic [4:0]  grid_w = 5'd1;
	logic [4:0]  grid_h = 5'd1;
	logic [4:0]  samples = 5'd16;

	// Predictor state, updated as transactions are accepted.
	logic signed [23:0] heights [HEIGHT_DEPTH];
	bit                 tile_flags [MAX_TILES];
	// Generator-side record of which heights have been written, so that no
	// query ever reaches an unwritten entry.
	bit                 filled [HEIGHT_DEPTH];

	txn_t    pending_txns[$];
	sample_t expected_samples[$];
	txn_t    cur_txn;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      errors = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Half-up rounding of a 16-fraction-bit blend (floor of s/65536 + 1/2).
	function automatic longint round_blend(longint s);
		return (s + 32768) >>> 16;
	endfunction

	function automatic longint cell_weight(longint rem, longint ts);
		if (rem <= 0)
			return 0;
		if (rem >= ts)
			return 65536;
		return (rem * 65536) / ts;
	endfunction

	// Tile pick, sample cell, corner addresses, weights and coverage for a query point.
	function automatic cell_t locate_cell(int qx, int qy);
		cell_t  c;
		longint ts, nx, ny, n, dx, dy, ui, uj, ti, tj, numx, numy, px, py, px1, py1;
		longint base;
		ts   = (tile_len == 0) ? 1 : longint'(tile_len);
		nx   = clampl(grid_w, 1, 16);
		ny   = clampl(grid_h, 1, 16);
		n    = clampl(samples, 2, MAX_SAMPLES);
		dx   = longint'(qx) - longint'(org_x);
		dy   = longint'(qy) - longint'(org_y);
		ui   = floor_div(dx, ts);
		uj   = floor_div(dy, ts);
		ti   = clampl(ui, 0, nx - 1);
		tj   = clampl(uj, 0, ny - 1);
		c.covered = ui >= 0 && uj >= 0 && ui < nx && uj < ny &&
			tile_flags[(uj * nx + ui) % MAX_TILES];
		numx = (dx - ti * ts) * (n - 1);
		numy = (dy - tj * ts) * (n - 1);
		px   = clampl(numx / ts, 0, n - 1);
		py   = clampl(numy / ts, 0, n - 1);
		px1  = (px + 1 < n) ? px + 1 : n - 1;
		py1  = (py + 1 < n) ? py + 1 : n - 1;
		c.wx = cell_weight(numx - px * ts, ts);
		c.wy = cell_weight(numy - py * ts, ts);
		base = ((tj * nx + ti) % MAX_TILES) * n * n;
		c.adr[0] = 16'((base + py * n + px) % HEIGHT_DEPTH);
		c.adr[1] = 16'((base + py * n + px1) % HEIGHT_DEPTH);
		c.adr[2] = 16'((base + py1 * n + px) % HEIGHT_DEPTH);
		c.adr[3] = 16'((base + py1 * n + px1) % HEIGHT_DEPTH);
		return c;
	endfunction

	// Applies one accepted transaction to the predictor state.
	function automatic void apply_txn(txn_t t);
		cell_t   c;
		longint  top, bot, r;
		sample_t s;
		case (t.kind)
			OP_WR_HEIGHT:  heights[t.addr] = t.value;
			OP_WR_PRESENT: tile_flags[t.addr % MAX_TILES] = t.present;
			OP_QUERY: begin
				c   = locate_cell(t.qx, t.qy);
				top = round_blend(longint'(heights[c.adr[0]]) * (65536 - c.wx) +
					longint'(heights[c.adr[1]]) * c.wx);
				bot = round_blend(longint'(heights[c.adr[2]]) * (65536 - c.wx) +
					longint'(heights[c.adr[3]]) * c.wx);
				r   = round_blend(top * (65536 - c.wy) + bot * c.wy);
				s.height  = r[23:0];
				s.covered = c.covered;
				expected_samples = {expected_samples, s};
			end
			default: ;
		endcase
	endfunction

	function automatic logic [23:0] rand_height();
		case ($urandom_range(9))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic void queue_height(logic [15:0] a, logic [23:0] v);
		txn_t t;
		t = '{OP_WR_HEIGHT, a, v, 1'($urandom_range(1)), int'($urandom), int'($urandom)};
		filled[a] = 1'b1;
		pending_txns = {pending_txns, t};
	endfunction

	function automatic void queue_flag(logic [15:0] a, logic b);
		txn_t t;
		t = '{OP_WR_PRESENT, a, 24'($urandom), b, int'($urandom), int'($urandom)};
		pending_txns = {pending_txns, t};
	endfunction

	// Queues a query, first filling any corner height not yet written.
	function automatic void queue_query(int qx, int qy);
		cell_t c;
		txn_t  t;
		c = locate_cell(qx, qy);
		for (int k = 0; k < 4; k++)
			if (!filled[c.adr[k]])
				queue_height(c.adr[k], rand_height());
		t = '{OP_QUERY, 16'($urandom), 24'($urandom), 1'($urandom_range(1)), qx, qy};
		pending_txns = {pending_txns, t};
	endfunction

	// A point near or inside the grid; the sum wraps into 32 bits on purpose.
	function automatic int grid_point(int o, logic [4:0] cnt);
		longint ts, tile, frac;
		ts = (tile_len == 0) ? 1 : longint'(tile_len);
		tile = longint'($urandom_range(32'(clampl(cnt, 1, 16) + 1))) - 1;
		frac = (longint'($urandom) << 8 | $urandom_range(255)) % ts;
		if ($urandom_range(7) == 0)
			frac = 0;
		return int'(longint'(o) + tile * ts + frac);
	endfunction

	function automatic void queue_random(int count);
		txn_t t;
		int   tiles;
		tiles = int'(clampl(grid_w, 1, 16) * clampl(grid_h, 1, 16));
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(19))
				0, 1, 2:
					queue_flag($urandom_range(3) == 0 ? 16'($urandom) :
						16'($urandom_range(tiles - 1)), $urandom_range(3) != 0);
				3:
					queue_height(16'($urandom), rand_height());
				4: begin
					// unknown kind: dropped by the block
					t = '{op_t'(2'd3), 16'($urandom), 24'($urandom),
						1'($urandom_range(1)), int'($urandom), int'($urandom)};
					pending_txns = {pending_txns, t};
				end
				5:
					queue_query(int'($urandom), int'($urandom));
				default:
					queue_query(grid_point(org_x, grid_w), grid_point(org_y, grid_h));
			endcase
		end
	endfunction

	// Short directed opener: extreme heights, wrapping addresses, odd points.
	function automatic void queue_directed();
		txn_t t;
		queue_height(16'd0, 24'h800000);
		queue_height(16'd1, 24'h7FFFFF);
		queue_height(16'd4, 24'h7FFFFF);
		queue_height(16'd5, 24'h800000);
		queue_height(16'hFFFF, 24'h123456);
		queue_flag(16'h0100, 1'b1);
		queue_flag(16'hFFFF, 1'b1);
		queue_flag(16'd5, 1'b1);
		t = '{op_t'(2'd3), 16'hFFFF, 24'hFFFFFF, 1'b1, -1, -1};
		pending_txns = {pending_txns, t};
		queue_query(org_x, org_y);
		queue_query(org_x + 50, org_y + 50);
		queue_query(org_x + 33, org_y + 66);
		queue_query(org_x - 1, org_y - 1);
		queue_query(org_x + 100, org_y + 100);
		queue_query(org_x + 399, org_y + 299);
		queue_query(org_x + 400, org_y + 300);
		queue_query(int'(32'h80000000), int'(32'h80000000));
		queue_query(int'(32'h7FFFFFFF), int'(32'h7FFFFFFF));
		queue_query(int'(32'h80000000), int'(32'h7FFFFFFF));
		queue_flag(16'd0, 1'b0);
		queue_query(org_x + 10, org_y + 10);
		queue_query(org_x + 150, org_y + 250);
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [31:0] d);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_ORIGIN_X:  org_x    = d;
			REG_ORIGIN_Y:  org_y    = d;
			REG_TILE_SIZE: tile_len = d[30:0];
			REG_TILES_X:   grid_w   = d[4:0];
			REG_TILES_Y:   grid_h   = d[4:0];
			REG_SAMPLES:   samples  = d[4:0];
			default: ;
		endcase
	endtask

	task automatic set_grid(int ox, int oy, logic [30:0] ts, logic [4:0] gx, logic [4:0] gy,
			logic [4:0] n);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_TILE_SIZE, {1'b0, ts});
		write_reg(REG_TILES_X, 32'(gx));
		write_reg(REG_TILES_Y, 32'(gy));
		write_reg(REG_SAMPLES, 32'(n));
	endtask

	// Waits for every pending transaction and result, then for the pipeline
	// to settle so that trailing writes have landed before a register write.
	task automatic drain();
		while (pending_txns.size() != 0 || s_axis_tvalid || expected_samples.size() != 0)
			@(negedge clk);
		repeat (45) @(posedge clk);
		@(negedge clk);
	endtask

	// Sender: presents the next queued transaction, feeding the predictor on
	// each accepted one.
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			apply_txn(cur_txn);
		if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_txns.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_txn       = pending_txns.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser  <= cur_txn.kind;
				s_axis_tdata  <= {7'd0, cur_txn.qy, cur_txn.qx, cur_txn.present,
					cur_txn.value, cur_txn.addr};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random backpressure and in-order comparison.
	always @(posedge clk) begin
		sample_t want;
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected result height=%h covered=%b", $time,
					m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = expected_samples.pop_front();
				if (m_axis_tdata !== want.height) begin
					$display("%0t: height expected %h actual %h", $time, want.height,
						m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser !== want.covered) begin
					$display("%0t: covered expected %b actual %b", $time, want.covered,
						m_axis_tuser);
					errors++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < 10; ph++) begin
			// idling modes cycle: none, sender idle, receiver stall, both
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			case (ph)
				0: ; // reset defaults: one tile, 16 samples
				1: begin
					set_grid(-500, 300, 31'd100, 5'd4, 5'd3, 5'd4);
					@(negedge clk);
					queue_directed();
				end
				// densest grid, x origin near the top and y origin at the bottom edge of the coordinate range
				2: set_grid(32'h7FFFFF00, 32'h80000000, 31'd7, 5'd16, 5'd16, 5'd2);
				// zero tile size and out-of-range counts saturate
				3: set_grid(0, 0, 31'd0, 5'd0, 5'd31, 5'd1);
				4: set_grid(32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF, 5'd2, 5'd2, 5'd16);
				5: set_grid(-3, 17, 31'd1, 5'd3, 5'd5, 5'd31);
				default: set_grid(int'($urandom), int'($urandom),
					$urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(1, 5000)),
					5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
					5'($urandom_range(2, 16)));
			endcase
			@(negedge clk);
			queue_random(18);
			drain();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== tiled_heightmap_bilinear_sampler.f =====
rtl/core/thbs_pkg.sv
rtl/core/thbs_ram.sv
rtl/core/thbs_front.sv
rtl/core/thbs_queue.sv
rtl/core/thbs_axis.sv
rtl/core/thbs_back.sv
rtl/core/tiled_heightmap_bilinear_sampler.sv
tb/tiled_heightmap_bilinear_sampler_test.sv
